// File: design/rbd_pkg.sv
`default_nettype none

package rbd_pkg;

   // register indexes on the csr port
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y = 2'd1;

   localparam int unsigned COORD_W = 11;
   localparam int unsigned SCREEN_W = 12;
   localparam int unsigned LUMA_SUM_W = 15;

   // channel expansion: v * 255 / max, truncated, worked out at elaboration
   localparam int unsigned Full8 = 255;
   localparam int unsigned Red5Max = 31;
   localparam int unsigned Grn6Max = 63;

   typedef logic [7:0] lut32_type [32];
   typedef logic [7:0] lut64_type [64];

   function automatic lut32_type build_lut32();
      lut32_type t;
      for (int i = 0; i < 32; i++) begin
         t[i] = 8'((i * Full8) / Red5Max);
      end
      return t;
   endfunction

   function automatic lut64_type build_lut64();
      lut64_type t;
      for (int i = 0; i < 64; i++) begin
         t[i] = 8'((i * Full8) / Grn6Max);
      end
      return t;
   endfunction

   localparam lut32_type EXPAND5 = build_lut32();
   localparam lut64_type EXPAND6 = build_lut64();

   // luminance weights, scaled by 100
   localparam logic [LUMA_SUM_W-1:0] WEIGHT_R = 15'd30;
   localparam logic [LUMA_SUM_W-1:0] WEIGHT_G = 15'd59;
   localparam logic [LUMA_SUM_W-1:0] WEIGHT_B = 15'd11;
   localparam logic [LUMA_SUM_W-1:0] LUMA_SCALE = 15'd100;

   typedef logic [5:0] dither_row_type [8];
   typedef dither_row_type dither_type [8];

   localparam dither_type DITHER8 = '{
      '{6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63},
      '{6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31},
      '{6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55},
      '{6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23},
      '{6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61},
      '{6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29},
      '{6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53},
      '{6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21}
   };

   typedef struct packed {
      logic [15:0]        color;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } pix_type;

   typedef struct packed {
      logic [7:0]          red;
      logic [7:0]          green;
      logic [7:0]          blue;
      logic [7:0]          thresh;
      logic [SCREEN_W-1:0] sx;
      logic [SCREEN_W-1:0] sy;
   } expand_type;

   typedef struct packed {
      logic [LUMA_SUM_W-1:0] luma_sum;
      logic [LUMA_SUM_W-1:0] limit;
      logic [SCREEN_W-1:0]   sx;
      logic [SCREEN_W-1:0]   sy;
   } luma_type;

   typedef struct packed {
      logic [SCREEN_W-1:0] sx;
      logic [SCREEN_W-1:0] sy;
      logic                black;
   } result_type;

endpackage

`default_nettype wire

// File: design/rbd_if.sv
`default_nettype none

interface rbd_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_color;
   logic [10:0] pixel_column;
   logic [10:0] pixel_row;

   modport source (output valid, output pixel_color, output pixel_column,
                   output pixel_row, input ready);
   modport sink (input valid, input pixel_color, input pixel_column,
                 input pixel_row, output ready);
endinterface

interface rbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] screen_x;
   logic [11:0] screen_y;
   logic        is_black;

   modport source (output valid, output screen_x, output screen_y,
                   output is_black, input ready);
   modport sink (input valid, input screen_x, input screen_y,
                 input is_black, output ready);
endinterface

`default_nettype wire

// File: design/rbd_expand.sv
`default_nettype none

module rbd_expand (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire rbd_pkg::pix_type               in_data,
   input  wire logic [rbd_pkg::COORD_W-1:0]    origin_x,
   input  wire logic [rbd_pkg::COORD_W-1:0]    origin_y,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output rbd_pkg::expand_type                 out_data
);

   logic                valid_ff;
   rbd_pkg::expand_type data_ff;
   rbd_pkg::expand_type data_in;
   logic [5:0]          dither;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      dither = rbd_pkg::DITHER8[in_data.row[2:0]][in_data.column[2:0]];
      data_in.red    = rbd_pkg::EXPAND5[in_data.color[15:11]];
      data_in.green  = rbd_pkg::EXPAND6[in_data.color[10:5]];
      data_in.blue   = rbd_pkg::EXPAND5[in_data.color[4:0]];
      // 2 + 4 * entry
      data_in.thresh = {dither, 2'b10};
      data_in.sx = {1'b0, origin_x} + {1'b0, in_data.column};
      data_in.sy = {1'b0, origin_y} + {1'b0, in_data.row};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// File: design/rbd_luma.sv
`default_nettype none

module rbd_luma (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire rbd_pkg::expand_type in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output rbd_pkg::luma_type        out_data
);

   logic              valid_ff;
   rbd_pkg::luma_type data_ff;
   rbd_pkg::luma_type data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      // luminance kept scaled by 100, so the divide folds into the limit
      data_in.luma_sum = rbd_pkg::LUMA_SUM_W'(in_data.red)   * rbd_pkg::WEIGHT_R
                       + rbd_pkg::LUMA_SUM_W'(in_data.green) * rbd_pkg::WEIGHT_G
                       + rbd_pkg::LUMA_SUM_W'(in_data.blue)  * rbd_pkg::WEIGHT_B;
      data_in.limit = rbd_pkg::LUMA_SUM_W'(in_data.thresh) * rbd_pkg::LUMA_SCALE;
      data_in.sx    = in_data.sx;
      data_in.sy    = in_data.sy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// File: design/rbd_decide.sv
`default_nettype none

module rbd_decide (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire rbd_pkg::luma_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output rbd_pkg::result_type    out_data
);

   logic                valid_ff;
   rbd_pkg::result_type data_ff;
   rbd_pkg::result_type data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      // floor(sum / 100) < t  is the same as  sum < 100 * t
      data_in.black = in_data.luma_sum < in_data.limit;
      data_in.sx    = in_data.sx;
      data_in.sy    = in_data.sy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// File: design/rgb565_bayer_dither_to_mono.sv
// RGB565 pixel to 1-bit screen pixel with 8x8 ordered dither.
// req_ch takes one word per pixel: pixel_color (RGB565), pixel_column and
// pixel_row inside the image. rsp_ch returns one word per pixel: screen_x and
// screen_y (origin plus column/row) and is_black.
// csr port: csr_write_enable with csr_index 0 writes origin_x, index 1
// writes origin_y from csr_wdata; other indexes are ignored. Write only
// while no pixel is in flight.
// A word accepted on req_ch passes through the expand, weighted sum and
// compare stages, each a register, before it shows on rsp_ch.
// Throughput: one pixel per cycle, set by the three-stage pipeline, unless
// rsp_ch stalls. Each stage holds while the next is full and stalled, so a
// stalled receiver fills the empty stages first and then drops req_ch.ready;
// nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and clears both
// origins to 0.
`default_nettype none

module rgb565_bayer_dither_to_mono (
   input  wire logic                              clock,
   input  wire logic                              reset,
   rbd_req_if.sink                                req_ch,
   rbd_rsp_if.source                              rsp_ch,
   input  wire logic                              csr_write_enable,
   input  wire logic [rbd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [rbd_pkg::COORD_W-1:0]       csr_wdata
);

   logic [rbd_pkg::COORD_W-1:0] origin_x_ff;
   logic [rbd_pkg::COORD_W-1:0] origin_y_ff;

   rbd_pkg::pix_type    pix;
   rbd_pkg::expand_type s1_data;
   rbd_pkg::luma_type   s2_data;
   rbd_pkg::result_type s3_data;
   logic                s1_valid;
   logic                s1_ready;
   logic                s2_valid;
   logic                s2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == rbd_pkg::CSR_ORIGIN_X) begin
            origin_x_ff <= csr_wdata;
         end else if (csr_index == rbd_pkg::CSR_ORIGIN_Y) begin
            origin_y_ff <= csr_wdata;
         end
      end
   end

   assign pix.color  = req_ch.pixel_color;
   assign pix.column = req_ch.pixel_column;
   assign pix.row    = req_ch.pixel_row;

   rbd_expand u_expand (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_data   (pix),
      .origin_x  (origin_x_ff),
      .origin_y  (origin_y_ff),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   rbd_luma u_luma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   rbd_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (s3_data)
   );

   assign rsp_ch.screen_x = s3_data.sx;
   assign rsp_ch.screen_y = s3_data.sy;
   assign rsp_ch.is_black = s3_data.black;

endmodule

`default_nettype wire

// File: design/rbd_checker.sv
`default_nettype none

module rbd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [11:0] rsp_screen_x,
   input wire logic [11:0] rsp_screen_y,
   input wire logic        rsp_is_black
);

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_screen_x)
         && $stable(rsp_screen_y) && $stable(rsp_is_black))
      else $error("stalled result word changed");

   // a free output side lets every stage move
   a_no_stall: assert property (@(posedge clock) rsp_ready |-> req_ready)
      else $error("input stalled while output ready");

   // an accepted word reaches the output when the receiver keeps taking words
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && rsp_ready) ##1 rsp_ready ##1 rsp_ready
         |=> rsp_valid)
      else $error("result word missing three cycles after acceptance");

endmodule

bind rgb565_bayer_dither_to_mono rbd_checker u_rbd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_screen_x (rsp_ch.screen_x),
   .rsp_screen_y (rsp_ch.screen_y),
   .rsp_is_black (rsp_ch.is_black)
);

`default_nettype wire

// File: test/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // indexes past the register list, writes there must be dropped
   localparam logic [rbd_pkg::CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [rbd_pkg::CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam int IDLE_PERCENT = 8;
   localparam int PIPE_DEPTH = 3;
   localparam int QUIET_LIMIT = 2000;
   localparam int PRINT_LIMIT = 40;
   localparam int RANDOM_SEGMENTS = 6;
   localparam int SEGMENT_PIXELS = 216;

   typedef struct packed {
      logic [rbd_pkg::SCREEN_W-1:0] x;
      logic [rbd_pkg::SCREEN_W-1:0] y;
      logic                         black;
   } mono_pixel_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_write_enable = 1'b0;
   logic [rbd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [rbd_pkg::COORD_W-1:0]     csr_wdata = '0;

   rbd_req_if req_ch ();
   rbd_rsp_if rsp_ch ();

   rgb565_bayer_dither_to_mono u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   mono_pixel_type              pending_pixels[$];
   logic [rbd_pkg::COORD_W-1:0] model_origin_x = '0;
   logic [rbd_pkg::COORD_W-1:0] model_origin_y = '0;
   int                          error_count = 0;
   int                          pixels_sent = 0;
   int                          words_checked = 0;
   int                          black_seen = 0;
   int                          origin_settings = 1;
   int                          quiet_cycles = 0;
   bit                          steady = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("ERROR: %s", msg);
      end
      error_count++;
   endtask

   // v * 255 / max, truncated
   function automatic int unsigned widen(input int unsigned v, input int unsigned vmax);
      return (v * 255) / vmax;
   endfunction

   // ordered-dither level: bit-reversed interleave of (col ^ row) and col
   function automatic logic [5:0] bayer_level(input logic [2:0] col, input logic [2:0] row);
      logic [2:0] mix;
      logic [5:0] lvl;
      mix = col ^ row;
      lvl = '0;
      for (int k = 0; k < 3; k++) begin
         lvl[5 - 2*k] = mix[k];
         lvl[4 - 2*k] = col[k];
      end
      return lvl;
   endfunction

   function automatic mono_pixel_type predict_mono_pixel(
         input logic [15:0] color,
         input logic [rbd_pkg::COORD_W-1:0] col,
         input logic [rbd_pkg::COORD_W-1:0] row);
      int unsigned red;
      int unsigned green;
      int unsigned blue;
      int unsigned luma;
      int unsigned limit;
      mono_pixel_type p;
      red = widen(32'(color[15:11]), 31);
      green = widen(32'(color[10:5]), 63);
      blue = widen(32'(color[4:0]), 31);
      luma = (30 * red + 59 * green + 11 * blue) / 100;
      limit = 2 + 4 * int'(bayer_level(col[2:0], row[2:0]));
      p.x = {1'b0, model_origin_x} + {1'b0, col};
      p.y = {1'b0, model_origin_y} + {1'b0, row};
      p.black = (luma < limit);
      return p;
   endfunction

   // receiver stalls at random unless in a steady stretch
   always @(posedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin : monitor
      mono_pixel_type want;
      if (!reset && req_ch.valid && req_ch.ready) begin
         pending_pixels.push_back(predict_mono_pixel(req_ch.pixel_color,
                                                     req_ch.pixel_column,
                                                     req_ch.pixel_row));
         pixels_sent++;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("word with nothing pending: x=%0d y=%0d black=%0b",
                                      rsp_ch.screen_x, rsp_ch.screen_y, rsp_ch.is_black));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_ch.screen_x !== want.x) begin
               report_mismatch($sformatf("screen_x %0d, want %0d", rsp_ch.screen_x, want.x));
            end
            if (rsp_ch.screen_y !== want.y) begin
               report_mismatch($sformatf("screen_y %0d, want %0d", rsp_ch.screen_y, want.y));
            end
            if (rsp_ch.is_black !== want.black) begin
               report_mismatch($sformatf("is_black %0b, want %0b at x=%0d y=%0d",
                                         rsp_ch.is_black, want.black, want.x, want.y));
            end
            words_checked++;
            if (want.black) begin
               black_seen++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_pixel(input logic [15:0] color,
                             input logic [rbd_pkg::COORD_W-1:0] col,
                             input logic [rbd_pkg::COORD_W-1:0] row);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pixel_color <= color;
      req_ch.pixel_column <= col;
      req_ch.pixel_row <= row;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic send_random_pixel();
      send_pixel(16'($urandom_range(0, 65535)), rbd_pkg::COORD_W'($urandom_range(0, 2047)),
                 rbd_pkg::COORD_W'($urandom_range(0, 2047)));
   endtask

   // hold the sender until every pending word is back
   task automatic drain_pixels();
      req_ch.valid <= 1'b0;
      // let the monitor log a word accepted at this edge first
      @(posedge clock);
      while (pending_pixels.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [rbd_pkg::CSR_INDEX_W-1:0] index,
                            input logic [rbd_pkg::COORD_W-1:0] value);
      drain_pixels();
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      unique case (index)
         rbd_pkg::CSR_ORIGIN_X: model_origin_x = value;
         rbd_pkg::CSR_ORIGIN_Y: model_origin_y = value;
         default: ;
      endcase
   endtask

   task automatic set_origin(input logic [rbd_pkg::COORD_W-1:0] ox,
                             input logic [rbd_pkg::COORD_W-1:0] oy);
      write_csr(rbd_pkg::CSR_ORIGIN_X, ox);
      write_csr(rbd_pkg::CSR_ORIGIN_Y, oy);
      origin_settings++;
   endtask

   // runs at the reset origin: black, white, each primary, smallest steps, greys
   task automatic test_colour_extremes();
      logic [15:0]                 colors[8] = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0,
                                                 16'h001F, 16'h0821, 16'h8410, 16'h7BEF};
      logic [rbd_pkg::COORD_W-1:0] cols[8] = '{11'd0, 11'd7, 11'd2047, 11'd1,
                                               11'd0, 11'd1024, 11'd5, 11'd2046};
      logic [rbd_pkg::COORD_W-1:0] rows[8] = '{11'd0, 11'd7, 11'd2047, 11'd0,
                                               11'd1, 11'd3, 11'd1536, 11'd6};
      for (int i = 0; i < 8; i++) begin
         send_pixel(colors[i], cols[i], rows[i]);
      end
   endtask

   // mid grey along one matrix row, so the threshold lands on both sides
   task automatic test_dither_row();
      for (int c = 0; c < 8; c++) begin
         send_pixel(16'h4208, rbd_pkg::COORD_W'(c), 11'd0);
      end
   endtask

   // largest origin plus largest column/row gives the top of the screen range
   task automatic test_position_limits();
      set_origin(11'd2047, 11'd2047);
      send_pixel(16'hFFFF, 11'd2047, 11'd2047);
      send_pixel(16'h0000, 11'd0, 11'd0);
      send_pixel(16'h8410, 11'd2047, 11'd0);
      send_pixel(16'h8410, 11'd0, 11'd2047);
   endtask

   task automatic test_spare_indexes();
      set_origin(11'd5, 11'd9);
      write_csr(CSR_SPARE_2, 11'd2047);
      write_csr(CSR_SPARE_3, 11'd1234);
      repeat (4) send_random_pixel();
   endtask

   task automatic test_random_pixels();
      for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
         unique case (seg)
            0: set_origin(11'd2047, 11'd0);
            1: set_origin(11'd0, 11'd2047);
            2: set_origin(11'd0, 11'd0);
            default: set_origin(rbd_pkg::COORD_W'($urandom_range(0, 2047)),
                                rbd_pkg::COORD_W'($urandom_range(0, 2047)));
         endcase
         steady = (seg == 2);
         for (int i = 0; i < SEGMENT_PIXELS; i++) begin
            if (seg == 3 && i == SEGMENT_PIXELS / 2) begin
               drain_pixels();
            end
            send_random_pixel();
         end
         steady = 1'b0;
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.pixel_color = '0;
      req_ch.pixel_column = '0;
      req_ch.pixel_row = '0;
      rsp_ch.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_colour_extremes();
      test_dither_row();
      test_position_limits();
      test_spare_indexes();
      test_random_pixels();

      drain_pixels();
      repeat (4 * PIPE_DEPTH) @(posedge clock);
      $display("%0d pixels sent through %0d origin settings, spare indexes written",
               pixels_sent, origin_settings);
      $display("%0d words checked, %0d drawn black, %0d mismatches",
               words_checked, black_seen, error_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
